FILE: rtl/hgrp_pkg.sv
// Package for the HTTP GET request parser: transaction structs, result and status codes,
// the fixed words the parser matches and the character helpers.
// No dependencies.
`default_nettype none

package hgrp_pkg;

    // Result queue, a power of two so the pointers wrap on their own
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] header_id;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_out;

    // Result kinds
    localparam logic [1:0] KIND_TARGET = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_METHOD  = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_VERSION = 2'd3;

    // Header identifiers
    localparam logic [1:0] HDR_RANGE    = 2'd0;
    localparam logic [1:0] HDR_IMS      = 2'd1;
    localparam logic [1:0] HDR_CONN     = 2'd2;
    localparam int         NUM_HDR      = 3;

    // Characters
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;

    localparam logic [8*4-1:0]  METHOD_WORD  = "GET ";
    localparam logic [8*7-1:0]  VERSION_WORD = "HTTP/1.";
    localparam logic [8*5-1:0]  NAME_RANGE   = "Range";
    localparam logic [8*17-1:0] NAME_IMS     = "If-Modified-Since";
    localparam logic [8*10-1:0] NAME_CONN    = "Connection";

    localparam logic [4:0] LEN_RANGE = 5'd5;
    localparam logic [4:0] LEN_IMS   = 5'd17;
    localparam logic [4:0] LEN_CONN  = 5'd10;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
        end
        return v;
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] pos);
        return METHOD_WORD[8*(3 - int'(pos)) +: 8];
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] c;
        c = 8'd0;
        if (pos < 3'd7) begin
            c = VERSION_WORD[8*(6 - int'(pos)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [4:0] name_len(input logic [1:0] id);
        logic [4:0] l;
        case (id)
            HDR_RANGE: l = LEN_RANGE;
            HDR_IMS:   l = LEN_IMS;
            default:   l = LEN_CONN;
        endcase
        return l;
    endfunction

    // Character at pos of a header name; callers check pos against name_len first
    function automatic logic [7:0] name_char(input logic [1:0] id, input logic [4:0] pos);
        logic [7:0] c;
        c = 8'd0;
        case (id)
            HDR_RANGE: if (pos < LEN_RANGE) c = NAME_RANGE[8*(4 - int'(pos)) +: 8];
            HDR_IMS:   if (pos < LEN_IMS)   c = NAME_IMS[8*(16 - int'(pos)) +: 8];
            default:   if (pos < LEN_CONN)  c = NAME_CONN[8*(9 - int'(pos)) +: 8];
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/http_get_request_parser.sv
// HTTP GET request parser: one request byte per transaction in, target bytes,
// selected header value bytes and a final status out. Uses hgrp_pkg.
//
// Each result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle; the byte step is one pass of logic into a
// four-entry result queue. A byte can yield a data result and the status together;
// input stalls while the queue has fewer than two free entries.
// Reset (i_rst_n low, synchronous) empties the queue and returns the parser to
// expecting the method.
`default_nettype none

module http_get_request_parser (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  hgrp_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output hgrp_pkg::t_out     o_out
);

    localparam logic [3:0] PH_METHOD   = 4'd0;
    localparam logic [3:0] PH_SLASH    = 4'd1;
    localparam logic [3:0] PH_TARGET   = 4'd2;
    localparam logic [3:0] PH_VERSION  = 4'd3;
    localparam logic [3:0] PH_NAME     = 4'd4;
    localparam logic [3:0] PH_BLANKCR  = 4'd5;
    localparam logic [3:0] PH_SKIPONE  = 4'd6;
    localparam logic [3:0] PH_SKIPLINE = 4'd7;
    localparam logic [3:0] PH_COLON    = 4'd8;
    localparam logic [3:0] PH_LEADING  = 4'd9;
    localparam logic [3:0] PH_VALUE    = 4'd10;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    logic [3:0] r_phase, n_phase;
    logic [4:0] r_mp, n_mp;
    logic [2:0] r_cand, n_cand;
    logic [1:0] r_hdr, n_hdr;
    logic [1:0] r_esc, n_esc;
    logic [3:0] r_hi, n_hi;
    logic       r_fin, n_fin;

    hgrp_pkg::t_out r_queue [hgrp_pkg::QDEPTH];
    logic [hgrp_pkg::QAW-1:0] r_wr, r_rd;
    logic [hgrp_pkg::QCW-1:0] r_count, n_count;

    logic           accept, pop;
    logic           d_valid, s_valid;
    hgrp_pkg::t_out d_res, s_res, first_res;
    logic [1:0]     s_code;
    logic [2:0]     keep;
    logic [7:0]     b;
    logic           eob;
    logic [hgrp_pkg::QCW-1:0] push_cnt;

    assign b   = i_in.data_byte;
    assign eob = i_in.end_of_buffer;

    assign o_in_stall  = (r_count > hgrp_pkg::QCW'(hgrp_pkg::QDEPTH - 2));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out       = r_queue[r_rd];

    // Byte step
    always_comb begin
        n_phase = r_phase;
        n_mp    = r_mp;
        n_cand  = r_cand;
        n_hdr   = r_hdr;
        n_esc   = r_esc;
        n_hi    = r_hi;
        n_fin   = r_fin;
        d_valid = 1'b0;
        d_res   = '0;
        s_valid = 1'b0;
        s_code  = hgrp_pkg::ST_OK;
        keep    = 3'b000;

        if (r_fin) begin
            if (eob) begin
                n_phase = PH_METHOD;
                n_mp    = '0;
                n_cand  = 3'b111;
                n_hdr   = '0;
                n_esc   = ESC_NONE;
                n_hi    = '0;
                n_fin   = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_METHOD: begin
                    if (r_mp > 5'd3) begin
                        s_valid = 1'b1;
                        s_code  = hgrp_pkg::ST_BAD;
                    end else if (b != hgrp_pkg::method_char(r_mp[1:0])) begin
                        s_valid = 1'b1;
                        s_code  = (r_mp < 5'd3) ? hgrp_pkg::ST_METHOD : hgrp_pkg::ST_BAD;
                    end else if (r_mp == 5'd3) begin
                        n_phase = PH_SLASH;
                        n_mp    = '0;
                    end else begin
                        n_mp = r_mp + 5'd1;
                    end
                end
                PH_SLASH: begin
                    n_phase = PH_TARGET;
                    n_esc   = ESC_NONE;
                end
                PH_TARGET: begin
                    d_res.kind = hgrp_pkg::KIND_TARGET;
                    if (b == hgrp_pkg::CH_SPACE) begin
                        // pending escape is flushed with missing digits as zero
                        if (r_esc == ESC_HIGH) begin
                            d_valid = 1'b1;
                        end else if (r_esc == ESC_LOW) begin
                            d_valid        = 1'b1;
                            d_res.out_byte = {r_hi, 4'd0};
                        end
                        n_esc   = ESC_NONE;
                        n_phase = PH_VERSION;
                        n_mp    = '0;
                    end else if (r_esc == ESC_HIGH) begin
                        n_hi  = hgrp_pkg::hex_value(b);
                        n_esc = ESC_LOW;
                    end else if (r_esc == ESC_LOW) begin
                        d_valid        = 1'b1;
                        d_res.out_byte = {r_hi, hgrp_pkg::hex_value(b)};
                        n_esc          = ESC_NONE;
                    end else if (b == hgrp_pkg::CH_PERCENT) begin
                        n_esc = ESC_HIGH;
                    end else begin
                        d_valid        = 1'b1;
                        d_res.out_byte = (b == hgrp_pkg::CH_PLUS) ? hgrp_pkg::CH_SPACE : b;
                    end
                end
                PH_VERSION: begin
                    if (r_mp < 5'd7) begin
                        if (b != hgrp_pkg::version_char(r_mp[2:0])) begin
                            s_valid = 1'b1;
                            s_code  = hgrp_pkg::ST_BAD;
                        end else begin
                            n_mp = r_mp + 5'd1;
                        end
                    end else if (r_mp == 5'd7) begin
                        if (b != hgrp_pkg::CH_ZERO && b != hgrp_pkg::CH_ONE) begin
                            s_valid = 1'b1;
                            s_code  = hgrp_pkg::ST_VERSION;
                        end else begin
                            n_mp = r_mp + 5'd1;
                        end
                    end else if (r_mp == 5'd8) begin
                        if (b != hgrp_pkg::CH_CR) begin
                            s_valid = 1'b1;
                            s_code  = hgrp_pkg::ST_BAD;
                        end else begin
                            n_mp = r_mp + 5'd1;
                        end
                    end else begin
                        if (b != hgrp_pkg::CH_LF) begin
                            s_valid = 1'b1;
                            s_code  = hgrp_pkg::ST_BAD;
                        end else begin
                            n_phase = PH_NAME;
                            n_mp    = '0;
                            n_cand  = 3'b111;
                        end
                    end
                end
                PH_NAME: begin
                    if (r_mp == '0 && b == hgrp_pkg::CH_CR) begin
                        n_phase = PH_BLANKCR;
                    end else begin
                        for (int i = 0; i < hgrp_pkg::NUM_HDR; i++) begin
                            keep[i] = r_cand[i] && (r_mp < hgrp_pkg::name_len(2'(i)))
                                      && (b == hgrp_pkg::name_char(2'(i), r_mp));
                        end
                        n_cand = keep;
                        if (keep == 3'b000) begin
                            n_phase = (b == hgrp_pkg::CH_CR) ? PH_SKIPONE : PH_SKIPLINE;
                        end else begin
                            // highest matching complete name wins
                            for (int i = 0; i < hgrp_pkg::NUM_HDR; i++) begin
                                if (keep[i] && (5'(r_mp + 5'd1) == hgrp_pkg::name_len(2'(i))))
                                begin
                                    n_hdr   = 2'(i);
                                    n_phase = PH_COLON;
                                end
                            end
                            if (n_phase == PH_NAME) begin
                                n_mp = r_mp + 5'd1;
                            end
                        end
                    end
                end
                PH_BLANKCR: begin
                    if (b == hgrp_pkg::CH_LF) begin
                        s_valid = 1'b1;
                        s_code  = hgrp_pkg::ST_OK;
                    end else begin
                        n_phase = PH_NAME;
                        n_mp    = '0;
                        n_cand  = 3'b111;
                    end
                end
                PH_SKIPONE: begin
                    n_phase = PH_NAME;
                    n_mp    = '0;
                    n_cand  = 3'b111;
                end
                PH_SKIPLINE: begin
                    if (b == hgrp_pkg::CH_CR) n_phase = PH_SKIPONE;
                end
                PH_COLON: begin
                    if (b != hgrp_pkg::CH_COLON) begin
                        s_valid = 1'b1;
                        s_code  = hgrp_pkg::ST_BAD;
                    end else begin
                        n_phase = PH_LEADING;
                    end
                end
                PH_LEADING, PH_VALUE: begin
                    d_res.kind      = hgrp_pkg::KIND_HEADER;
                    d_res.header_id = r_hdr;
                    d_res.out_byte  = b;
                    if (b == hgrp_pkg::CH_CR) begin
                        n_phase = PH_SKIPONE;
                    end else if (r_phase == PH_LEADING &&
                                 (b == hgrp_pkg::CH_SPACE || b == hgrp_pkg::CH_TAB)) begin
                        n_phase = PH_LEADING;
                    end else begin
                        d_valid = 1'b1;
                        n_phase = PH_VALUE;
                    end
                end
                default: begin
                    s_valid = 1'b1;
                    s_code  = hgrp_pkg::ST_BAD;
                end
            endcase

            if (!s_valid && eob) begin
                s_valid = 1'b1;
                s_code  = hgrp_pkg::ST_BAD;
            end
            if (s_valid) begin
                n_fin = 1'b1;
                if (eob) begin
                    n_phase = PH_METHOD;
                    n_mp    = '0;
                    n_cand  = 3'b111;
                    n_hdr   = '0;
                    n_esc   = ESC_NONE;
                    n_hi    = '0;
                    n_fin   = 1'b0;
                end
            end
        end
    end

    always_comb begin
        s_res        = '0;
        s_res.kind   = hgrp_pkg::KIND_STATUS;
        s_res.status = s_code;
        s_res.last   = 1'b1;
        first_res    = d_valid ? d_res : s_res;
        push_cnt     = '0;
        if (accept) begin
            push_cnt = hgrp_pkg::QCW'({1'b0, d_valid} + {1'b0, s_valid});
        end
        n_count = r_count + push_cnt - hgrp_pkg::QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_mp    <= '0;
            r_cand  <= 3'b111;
            r_hdr   <= '0;
            r_esc   <= ESC_NONE;
            r_hi    <= '0;
            r_fin   <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_mp    <= n_mp;
                r_cand  <= n_cand;
                r_hdr   <= n_hdr;
                r_esc   <= n_esc;
                r_hi    <= n_hi;
                r_fin   <= n_fin;
            end
            r_wr    <= r_wr + push_cnt[hgrp_pkg::QAW-1:0];
            r_rd    <= r_rd + hgrp_pkg::QAW'(pop);
            r_count <= n_count;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (accept && (d_valid || s_valid)) begin
            r_queue[r_wr] <= first_res;
        end
        if (accept && d_valid && s_valid) begin
            r_queue[r_wr + hgrp_pkg::QAW'(1)] <= s_res;
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hgrp_pkg::QCW'(hgrp_pkg::QDEPTH))
        else $error("result queue overfilled");

    a_silent_after_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_fin |-> push_cnt == '0)
        else $error("result produced after the final status");

    a_status_marks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_valid && !eob |=> r_fin)
        else $error("status emitted without ending the request");

    a_pair_is_data_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_cnt == hgrp_pkg::QCW'(2) |-> d_valid && s_valid)
        else $error("two results from one byte that are not data plus status");

    a_fin_clears_on_eob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && eob |=> !r_fin && r_phase == PH_METHOD)
        else $error("parser not restarted after end of buffer");

endmodule

`default_nettype wire

FILE: test/tb_http_get_request_parser.sv
// Self-checking testbench for http_get_request_parser: a directed table, then random requests,
// with typed rows checked against their own expectation and all else against a byte-level predictor.
// Depends on hgrp_pkg and the parser RTL only.
module tb_http_get_request_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [1:0] NO_HDR   = 2'd0;
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    typedef enum logic [3:0] {
        P_METHOD, P_SLASH, P_TARGET, P_VERSION, P_NAME, P_BLANKCR,
        P_SKIPONE, P_SKIPLINE, P_COLON, P_LEADING, P_VALUE
    } t_stage;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic [7:0]     b;
        logic           eob;
        logic           typed;
        logic           has_res;
        hgrp_pkg::t_out res;
    } t_row;

    localparam hgrp_pkg::t_out R_NONE   = '0;
    localparam hgrp_pkg::t_out R_METHOD = '{kind: hgrp_pkg::KIND_STATUS, header_id: NO_HDR,
                                            out_byte: 8'h00, status: hgrp_pkg::ST_METHOD,
                                            last: 1'b1};
    localparam hgrp_pkg::t_out R_BAD    = '{kind: hgrp_pkg::KIND_STATUS, header_id: NO_HDR,
                                            out_byte: 8'h00, status: hgrp_pkg::ST_BAD,
                                            last: 1'b1};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    hgrp_pkg::t_in  in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    hgrp_pkg::t_out out_item;

    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int cycles = 0;

    hgrp_pkg::t_out pending_results[$];
    hgrp_pkg::t_out step_results[$];
    logic [7:0] req_bytes[$];

    // Parser state as the predictor sees it
    t_stage     stage;
    logic [4:0] pos;
    logic [2:0] cand;
    logic [1:0] hdr;
    logic [1:0] esc;
    logic [3:0] nib;
    logic       done;

    string GET_WORD = "GET ";
    string VER_WORD = "HTTP/1.";
    string hdr_name [3] = '{"Range", "If-Modified-Since", "Connection"};
    string other_name [4] = '{"Host", "Accept", "range", "Ranges"};

    t_row script [20] = '{
        '{"X",   1'b1, 1'b1, 1'b1, R_METHOD},  // wrong first letter, buffer ends
        '{"G",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"E",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"T",   1'b1, 1'b1, 1'b1, R_BAD},     // buffer runs out inside the method
        '{8'hFF, 1'b0, 1'b1, 1'b1, R_METHOD},
        '{8'h00, 1'b1, 1'b1, 1'b0, R_NONE},    // ignored after the status
        '{"G",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"E",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"T",   1'b0, 1'b0, 1'b0, R_NONE},
        '{" ",   1'b0, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, R_NONE},    // skipped slash position
        '{"+",   1'b0, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b0, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, R_NONE},
        '{"%",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"a",   1'b0, 1'b0, 1'b0, R_NONE},
        '{" ",   1'b0, 1'b0, 1'b0, R_NONE},    // escape cut short by the space
        '{"H",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"T",   1'b0, 1'b0, 1'b0, R_NONE},
        '{"X",   1'b1, 1'b1, 1'b1, R_BAD}
    };

    http_get_request_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
        return v;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [1:0] hid,
                                 input logic [7:0] ob, input logic [1:0] code,
                                 input logic lst);
        hgrp_pkg::t_out r;
        r = '{kind: kind, header_id: hid, out_byte: ob, status: code, last: lst};
        step_results.push_back(r);
    endfunction

    function automatic void parser_restart();
        stage = P_METHOD;
        pos   = '0;
        cand  = 3'b111;
        hdr   = '0;
        esc   = ESC_IDLE;
        nib   = '0;
        done  = 1'b0;
    endfunction

    function automatic void new_line();
        stage = P_NAME;
        pos   = '0;
        cand  = 3'b111;
    endfunction

    // Advances the predicted parser by one byte; results land in step_results
    function automatic void parse_byte(input logic [7:0] b, input logic eob);
        logic       fin;
        logic [1:0] code;
        logic [2:0] keep;
        fin  = 1'b0;
        code = hgrp_pkg::ST_OK;
        keep = '0;
        step_results.delete();
        if (done) begin
            if (eob) parser_restart();
        end else begin
            case (stage)
                P_METHOD: begin
                    if (pos > 5'd3) begin
                        fin = 1'b1; code = hgrp_pkg::ST_BAD;
                    end else if (b != 8'(GET_WORD[pos])) begin
                        fin = 1'b1;
                        code = (pos < 5'd3) ? hgrp_pkg::ST_METHOD : hgrp_pkg::ST_BAD;
                    end else if (pos == 5'd3) begin
                        stage = P_SLASH; pos = '0;
                    end else begin
                        pos++;
                    end
                end
                P_SLASH: begin
                    stage = P_TARGET;
                    esc = ESC_IDLE;
                end
                P_TARGET: begin
                    if (b == hgrp_pkg::CH_SPACE) begin
                        if (esc == ESC_HIGH)
                            emit(hgrp_pkg::KIND_TARGET, NO_HDR, 8'h00, hgrp_pkg::ST_OK, 1'b0);
                        else if (esc == ESC_LOW)
                            emit(hgrp_pkg::KIND_TARGET, NO_HDR, {nib, 4'h0},
                                 hgrp_pkg::ST_OK, 1'b0);
                        esc = ESC_IDLE; stage = P_VERSION; pos = '0;
                    end else if (esc == ESC_HIGH) begin
                        nib = nibble_of(b); esc = ESC_LOW;
                    end else if (esc == ESC_LOW) begin
                        emit(hgrp_pkg::KIND_TARGET, NO_HDR, {nib, nibble_of(b)},
                             hgrp_pkg::ST_OK, 1'b0);
                        esc = ESC_IDLE;
                    end else if (b == hgrp_pkg::CH_PERCENT) begin
                        esc = ESC_HIGH;
                    end else begin
                        emit(hgrp_pkg::KIND_TARGET, NO_HDR,
                             (b == hgrp_pkg::CH_PLUS) ? hgrp_pkg::CH_SPACE : b,
                             hgrp_pkg::ST_OK, 1'b0);
                    end
                end
                P_VERSION: begin
                    if (pos < 5'd7) begin
                        if (b != 8'(VER_WORD[pos])) begin
                            fin = 1'b1; code = hgrp_pkg::ST_BAD;
                        end else pos++;
                    end else if (pos == 5'd7) begin
                        if (b != hgrp_pkg::CH_ZERO && b != hgrp_pkg::CH_ONE) begin
                            fin = 1'b1; code = hgrp_pkg::ST_VERSION;
                        end else pos++;
                    end else if (pos == 5'd8) begin
                        if (b != hgrp_pkg::CH_CR) begin
                            fin = 1'b1; code = hgrp_pkg::ST_BAD;
                        end else pos++;
                    end else begin
                        if (b != hgrp_pkg::CH_LF) begin
                            fin = 1'b1; code = hgrp_pkg::ST_BAD;
                        end else new_line();
                    end
                end
                P_NAME: begin
                    if (pos == 5'd0 && b == hgrp_pkg::CH_CR) begin
                        stage = P_BLANKCR;
                    end else begin
                        for (int i = 0; i < hgrp_pkg::NUM_HDR; i++)
                            if (cand[i] && int'(pos) < hdr_name[i].len() &&
                                b == 8'(hdr_name[i][pos]))
                                keep[i] = 1'b1;
                        cand = keep;
                        if (keep == 3'b000) begin
                            stage = (b == hgrp_pkg::CH_CR) ? P_SKIPONE : P_SKIPLINE;
                        end else begin
                            for (int i = 0; i < hgrp_pkg::NUM_HDR; i++)
                                if (keep[i] && int'(pos) + 1 == hdr_name[i].len()) begin
                                    hdr = 2'(i);
                                    stage = P_COLON;
                                end
                            if (stage == P_NAME) pos++;
                        end
                    end
                end
                P_BLANKCR: begin
                    if (b == hgrp_pkg::CH_LF) begin
                        fin = 1'b1; code = hgrp_pkg::ST_OK;
                    end else new_line();
                end
                P_SKIPONE: new_line();
                P_SKIPLINE: if (b == hgrp_pkg::CH_CR) stage = P_SKIPONE;
                P_COLON: begin
                    if (b != hgrp_pkg::CH_COLON) begin
                        fin = 1'b1; code = hgrp_pkg::ST_BAD;
                    end else stage = P_LEADING;
                end
                P_LEADING: begin
                    if (b == hgrp_pkg::CH_CR) begin
                        stage = P_SKIPONE;
                    end else if (b != hgrp_pkg::CH_SPACE && b != hgrp_pkg::CH_TAB) begin
                        emit(hgrp_pkg::KIND_HEADER, hdr, b, hgrp_pkg::ST_OK, 1'b0);
                        stage = P_VALUE;
                    end
                end
                P_VALUE: begin
                    if (b == hgrp_pkg::CH_CR) stage = P_SKIPONE;
                    else emit(hgrp_pkg::KIND_HEADER, hdr, b, hgrp_pkg::ST_OK, 1'b0);
                end
                default: begin
                    fin = 1'b1; code = hgrp_pkg::ST_BAD;
                end
            endcase
            if (!fin && eob) begin
                fin = 1'b1; code = hgrp_pkg::ST_BAD;
            end
            if (fin) begin
                emit(hgrp_pkg::KIND_STATUS, NO_HDR, 8'h00, code, 1'b1);
                done = 1'b1;
                if (eob) parser_restart();
            end
        end
    endfunction

    function automatic void add_text(input string s);
        foreach (s[i]) req_bytes.push_back(8'(s[i]));
    endfunction

    function automatic logic [7:0] target_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = hgrp_pkg::CH_PERCENT;
            2:       c = hgrp_pkg::CH_PLUS;
            3:       c = 8'("0") + 8'($urandom_range(0, 9));
            4:       c = 8'("a") + 8'($urandom_range(0, 5));
            5:       c = 8'("A") + 8'($urandom_range(0, 5));
            6:       c = 8'("g") + 8'($urandom_range(0, 19));
            7:       c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(8'h21, 8'h7e));
        endcase
        return c;
    endfunction

    // Builds one request buffer, mostly well formed; returns the count of bytes before any trailing junk
    function automatic int build_request();
        int body;
        int sel;
        string nm;
        req_bytes.delete();
        if ($urandom_range(0, 19) == 0) begin
            add_text(GET_WORD.substr(0, $urandom_range(0, 3) - 1));
            req_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_text(GET_WORD);
        end
        req_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : 8'("/"));
        repeat ($urandom_range(0, 8)) req_bytes.push_back(target_char());
        add_text(" HTTP/1.");
        if ($urandom_range(0, 29) == 0)
            req_bytes[req_bytes.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) req_bytes.push_back(8'($urandom_range(0, 255)));
        else req_bytes.push_back($urandom_range(0, 1) ? hgrp_pkg::CH_ONE : hgrp_pkg::CH_ZERO);
        req_bytes.push_back(($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                                         : hgrp_pkg::CH_CR);
        req_bytes.push_back(($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                                         : hgrp_pkg::CH_LF);
        repeat ($urandom_range(0, 3)) begin
            sel = $urandom_range(0, 9);
            if (sel == 9) begin
                // stray CR at the start of a line, then a byte above LF
                req_bytes.push_back(hgrp_pkg::CH_CR);
                req_bytes.push_back(8'($urandom_range(11, 255)));
            end else begin
                if (sel < 6) nm = hdr_name[sel % 3];
                else if (sel == 6) nm = other_name[$urandom_range(0, 3)];
                else begin
                    nm = hdr_name[$urandom_range(0, 2)];
                    nm = nm.substr(0, $urandom_range(1, nm.len() - 1) - 1);
                end
                add_text(nm);
                req_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                                 : hgrp_pkg::CH_COLON);
                repeat ($urandom_range(0, 2))
                    req_bytes.push_back($urandom_range(0, 1) ? hgrp_pkg::CH_TAB
                                                             : hgrp_pkg::CH_SPACE);
                repeat ($urandom_range(0, 5))
                    req_bytes.push_back($urandom_range(0, 2) ? 8'($urandom_range(8'h21, 8'h7e))
                                                             : 8'($urandom_range(0, 255)));
                req_bytes.push_back(hgrp_pkg::CH_CR);
                req_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                                : hgrp_pkg::CH_LF);
            end
        end
        req_bytes.push_back(hgrp_pkg::CH_CR);
        req_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                         : hgrp_pkg::CH_LF);
        if ($urandom_range(0, 9) == 0)
            while (req_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(req_bytes.pop_back());
        body = req_bytes.size();
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
        return body;
    endfunction

    task automatic push_byte(input t_row r);
        @(negedge clk);
        while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = '{data_byte: r.b, end_of_buffer: r.eob};
        do @(posedge clk); while (in_stall);
        parse_byte(r.b, r.eob);
        if (r.typed) begin
            if (r.has_res) pending_results.push_back(r.res);
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic log_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    always @(negedge clk)
        out_stall <= (recv_idle != 0) && ($urandom_range(0, 99) < recv_idle);

    always @(posedge clk) begin : check_results
        hgrp_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                log_error($sformatf("unexpected result kind %0d byte %02h status %0d",
                                    out_item.kind, out_item.out_byte, out_item.status));
            end else begin
                want = pending_results.pop_front();
                if (out_item.kind !== want.kind || out_item.header_id !== want.header_id ||
                    out_item.out_byte !== want.out_byte || out_item.status !== want.status ||
                    out_item.last !== want.last)
                    log_error({$sformatf("mismatch: exp kind %0d hdr %0d byte %02h st %0d",
                                         want.kind, want.header_id, want.out_byte,
                                         want.status),
                               $sformatf(" last %0d, got %0d %0d %02h %0d %0d", want.last,
                                         out_item.kind, out_item.header_id, out_item.out_byte,
                                         out_item.status, out_item.last)});
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int sent;
        int body;
        t_row r;
        parser_restart();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i]) push_byte(script[i]);

        // idle mix per phase: none, sender only, receiver only, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1) ? 46 : (ph == 3) ? 29 : 0;
            recv_idle = (ph == 2) ? 46 : (ph == 3) ? 29 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                body = build_request();
                sent += body;
                for (int k = 0; k < req_bytes.size(); k++) begin
                    r = '{b: req_bytes[k], eob: 1'(k == req_bytes.size() - 1),
                          typed: 1'b0, has_res: 1'b0, res: R_NONE};
                    push_byte(r);
                end
            end
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: http_get_request_parser.f
rtl/hgrp_pkg.sv
rtl/http_get_request_parser.sv
test/tb_http_get_request_parser.sv
